/* rtl/c2dpp_pkg.sv */
// Shared package for the 2D replicate-pad convolution core.
// Holds geometry defaults, item and register codes, and the controller/datapath types.
// No dependencies.
package c2dpp_pkg;

	localparam int MAX_COLS_DEF   = 256;
	localparam int MAX_RADIUS_DEF = 2;
	localparam int SAMPLE_BITS    = 16;
	localparam int MAX_ROWS       = 1024;
	localparam int ROW_W          = 10;
	localparam int ROWS_W         = 11;

	// item operation codes (tuser on the slave side)
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_PIXEL = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_RADIUS = 3'd0;
	localparam logic [2:0] CFG_COLS   = 3'd1;
	localparam logic [2:0] CFG_ROWS   = 3'd2;
	localparam logic [2:0] CFG_ACT    = 3'd3;
	localparam logic [2:0] CFG_BIAS   = 3'd4;
	localparam logic [2:0] CFG_SLOPE  = 3'd5;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_TAP_START,
		CMD_TAP_STEP,
		CMD_BIAS,
		CMD_MUL_HI,
		CMD_MUL_LO,
		CMD_COMBINE,
		CMD_ROUND,
		CMD_EMIT
	} dp_cmd_t;

	typedef struct packed {
		logic emit_ok;
		logic tap_last;
		logic mac_busy;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/c2dpp_ctrl.sv */
// Controller for the convolution core: sequences accept, window walk,
// activation steps and output load. Depends on c2dpp_pkg.
module c2dpp_ctrl import c2dpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TAPS,
		ST_DRAIN,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_COMBINE,
		ST_ROUND,
		ST_OUT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = CMD_NONE;
		unique case (state_q)
			ST_IDLE:    if (in_valid) cmd = CMD_ACCEPT;
			ST_CHECK:   if (status.emit_ok) cmd = CMD_TAP_START;
			ST_TAPS:    cmd = CMD_TAP_STEP;
			ST_DRAIN:   if (!status.mac_busy) cmd = CMD_BIAS;
			ST_MUL_HI:  cmd = CMD_MUL_HI;
			ST_MUL_LO:  cmd = CMD_MUL_LO;
			ST_COMBINE: cmd = CMD_COMBINE;
			ST_ROUND:   cmd = CMD_ROUND;
			ST_OUT:     if (status.out_free) cmd = CMD_EMIT;
			default:    cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:    if (in_valid) state_q <= ST_CHECK;
				ST_CHECK:   state_q <= status.emit_ok ? ST_TAPS : ST_IDLE;
				ST_TAPS:    if (status.tap_last) state_q <= ST_DRAIN;
				ST_DRAIN:   if (!status.mac_busy) state_q <= ST_MUL_HI;
				ST_MUL_HI:  state_q <= ST_MUL_LO;
				ST_MUL_LO:  state_q <= ST_COMBINE;
				ST_COMBINE: state_q <= ST_ROUND;
				ST_ROUND:   state_q <= ST_OUT;
				ST_OUT:     if (status.out_free) state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/c2dpp_dp.sv */
// Datapath for the convolution core: registers, line ring memory, coefficient
// store, counters, MAC pipeline, bias/PReLU and output word. Depends on c2dpp_pkg.
module c2dpp_dp import c2dpp_pkg::*; #(
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic [1:0]        in_op,
	input  logic [4:0]        in_cidx,
	input  logic signed [15:0] in_sample,
	input  dp_cmd_t           cmd,
	output dp_status_t        status,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       out_pixel,
	output logic [ROW_W-1:0]  out_row,
	output logic [7:0]        out_col,
	output logic              out_last,
	output logic              out_sat
);

	localparam int RL    = 2 * MAX_RADIUS + 2;
	localparam int KSIDE = 2 * MAX_RADIUS + 1;
	localparam int KN    = KSIDE * KSIDE;
	localparam int CW    = $clog2(MAX_COLS);
	localparam int CLW   = CW + 1;
	localparam int SCW   = CW + 3;
	localparam int RADW  = $clog2(MAX_RADIUS + 1);
	localparam int DW    = $clog2(KSIDE);
	localparam int KW    = $clog2(KN);
	localparam int RGW   = $clog2(RL);
	localparam int DEPTH = RL * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int ACCW  = 32 + KW + 1;
	localparam int VW    = ACCW + 1;
	localparam int LOW   = 20;
	localparam int PW    = VW + 16;

	// configuration
	logic [1:0]         radius_q;
	logic [8:0]         cols_q;
	logic [10:0]        rows_q;
	logic               act_q;
	logic signed [15:0] bias_q;
	logic signed [15:0] slope_q;

	// frame counters
	logic [ROW_W-1:0] irow_q, orow_q;
	logic [CW-1:0]    icol_q, ocol_q;
	logic [RGW-1:0]   iring_q, oring_q;
	logic             complete_q;

	// stores
	logic signed [15:0] line_mem [DEPTH];
	logic signed [15:0] coef_mem [KN];

	// window walk and MAC pipe
	logic [DW-1:0] dr_q, dc_q;
	logic [KW-1:0] ki_q;
	logic signed [15:0] px_s1, cf_s1;
	logic               v_s1, v_s2;
	logic signed [31:0] prod_s2;
	logic signed [ACCW-1:0] acc_q;
	logic signed [VW-1:0]   v_q;
	logic signed [VW-LOW+15:0] phi_q;
	logic signed [LOW+16:0]    plo_q;
	logic signed [PW-1:0]      prod_q;
	logic signed [PW-1:0]      res_q;

	logic [RADW-1:0]   r_eff;
	logic [CLW-1:0]    cols_eff;
	logic [ROWS_W-1:0] rows_eff;
	logic [DW-1:0]     span;

	always_comb begin
		if (32'(radius_q) > MAX_RADIUS) r_eff = RADW'(MAX_RADIUS);
		else r_eff = RADW'(radius_q);
		if (cols_q == 9'd0) cols_eff = CLW'(1);
		else if (32'(cols_q) > MAX_COLS) cols_eff = CLW'(MAX_COLS);
		else cols_eff = CLW'(cols_q);
		if (rows_q == 11'd0) rows_eff = ROWS_W'(1);
		else if (32'(rows_q) > MAX_ROWS) rows_eff = ROWS_W'(MAX_ROWS);
		else rows_eff = rows_q;
		span = DW'({r_eff, 1'b0});
	end

	// output emit test: whole clamped window has arrived
	logic [ROWS_W-1:0] rr;
	logic [CLW-1:0]    cc;
	always_comb begin
		rr = ROWS_W'(orow_q) + ROWS_W'(r_eff);
		if (rr > rows_eff - 1'b1) rr = rows_eff - 1'b1;
		cc = CLW'(ocol_q) + CLW'(r_eff);
		if (cc > cols_eff - 1'b1) cc = cols_eff - 1'b1;
	end

	assign status.emit_ok = complete_q || (ROWS_W'(irow_q) > rr) ||
		((ROWS_W'(irow_q) == rr) && (CLW'(icol_q) > cc));
	assign status.tap_last = (dr_q == span) && (dc_q == span);
	assign status.mac_busy = v_s1 || v_s2;
	assign status.out_free = !out_valid || out_ready;

	// tap address with replicated edges
	logic signed [12:0]    pr_s, d_s, ring_s;
	logic signed [SCW-1:0] pc_s;
	logic [CW-1:0]         pc;
	logic [AW-1:0]         rd_addr, wr_addr;
	always_comb begin
		pr_s = $signed(13'(orow_q)) + $signed(13'(dr_q)) - $signed(13'(r_eff));
		if (pr_s < 0) pr_s = '0;
		else if (pr_s > $signed(13'(rows_eff - 1'b1))) pr_s = $signed(13'(rows_eff - 1'b1));
		d_s = pr_s - $signed(13'(orow_q));
		ring_s = $signed(13'(oring_q)) + d_s;
		if (ring_s < 0) ring_s = ring_s + 13'(RL);
		else if (ring_s >= $signed(13'(RL))) ring_s = ring_s - 13'(RL);
		pc_s = $signed(SCW'(ocol_q)) + $signed(SCW'(dc_q)) - $signed(SCW'(r_eff));
		if (pc_s < 0) pc_s = '0;
		else if (pc_s > $signed(SCW'(cols_eff - 1'b1))) pc_s = $signed(SCW'(cols_eff - 1'b1));
		pc = CW'(pc_s);
		rd_addr = AW'(32'(RGW'(ring_s)) * MAX_COLS + 32'(pc));
		wr_addr = AW'(32'(iring_q) * MAX_COLS + 32'(icol_q));
	end

	logic pix_wr, coef_wr;
	assign pix_wr  = (cmd == CMD_ACCEPT) && (in_op == OP_PIXEL) && !complete_q;
	assign coef_wr = (cmd == CMD_ACCEPT) && (in_op == OP_LOAD) && (32'(in_cidx) < KN);

	// memories
	always_ff @(posedge clk) begin
		if (pix_wr) line_mem[wr_addr] <= in_sample;
		if (coef_wr) coef_mem[KW'(in_cidx)] <= in_sample;
		if (cmd == CMD_TAP_STEP) begin
			px_s1 <= line_mem[rd_addr];
			cf_s1 <= coef_mem[ki_q];
		end
	end

	logic restart;
	assign restart = cfg_we && (cfg_index == CFG_RADIUS || cfg_index == CFG_COLS ||
		cfg_index == CFG_ROWS);

	// config and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= 2'd1;
			cols_q     <= 9'd176;
			rows_q     <= 11'd144;
			act_q      <= 1'b0;
			bias_q     <= '0;
			slope_q    <= '0;
			irow_q     <= '0;
			icol_q     <= '0;
			iring_q    <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
			oring_q    <= '0;
			complete_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RADIUS: radius_q <= cfg_data[1:0];
					CFG_COLS:   cols_q   <= cfg_data[8:0];
					CFG_ROWS:   rows_q   <= cfg_data[10:0];
					CFG_ACT:    act_q    <= cfg_data[0];
					CFG_BIAS:   bias_q   <= cfg_data;
					CFG_SLOPE:  slope_q  <= cfg_data;
					default:    ;
				endcase
			end
			if (restart) begin
				irow_q     <= '0;
				icol_q     <= '0;
				iring_q    <= '0;
				orow_q     <= '0;
				ocol_q     <= '0;
				oring_q    <= '0;
				complete_q <= 1'b0;
			end else begin
				if (pix_wr) begin
					if (CLW'(icol_q) + 1'b1 >= cols_eff) begin
						icol_q <= '0;
						if (ROWS_W'(irow_q) + 1'b1 >= rows_eff) begin
							irow_q     <= '0;
							iring_q    <= '0;
							complete_q <= 1'b1;
						end else begin
							irow_q  <= irow_q + 1'b1;
							iring_q <= (32'(iring_q) == RL - 1) ? '0 : iring_q + 1'b1;
						end
					end else begin
						icol_q <= icol_q + 1'b1;
					end
				end
				if (cmd == CMD_EMIT) begin
					if (CLW'(ocol_q) + 1'b1 >= cols_eff) begin
						ocol_q <= '0;
						if (ROWS_W'(orow_q) + 1'b1 >= rows_eff) begin
							orow_q     <= '0;
							oring_q    <= '0;
							complete_q <= 1'b0;
						end else begin
							orow_q  <= orow_q + 1'b1;
							oring_q <= (32'(oring_q) == RL - 1) ? '0 : oring_q + 1'b1;
						end
					end else begin
						ocol_q <= ocol_q + 1'b1;
					end
				end
			end
		end
	end

	// window walk and MAC valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dr_q <= '0;
			dc_q <= '0;
			ki_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (cmd == CMD_TAP_STEP);
			v_s2 <= v_s1;
			if (cmd == CMD_TAP_START) begin
				dr_q <= '0;
				dc_q <= '0;
				ki_q <= '0;
			end else if (cmd == CMD_TAP_STEP) begin
				ki_q <= ki_q + 1'b1;
				if (dc_q == span) begin
					dc_q <= '0;
					dr_q <= dr_q + 1'b1;
				end else begin
					dc_q <= dc_q + 1'b1;
				end
			end
		end
	end

	logic signed [PW-1:0] pos_base;
	assign pos_base = act_q ? PW'(v_q) : PW'(acc_q);

	// arithmetic
	always_ff @(posedge clk) begin
		prod_s2 <= px_s1 * cf_s1;
		if (cmd == CMD_TAP_START) acc_q <= '0;
		else if (v_s2) acc_q <= acc_q + ACCW'(prod_s2);
		case (cmd)
			CMD_BIAS:    v_q <= VW'(acc_q) + (VW'(bias_q) <<< 13);
			CMD_MUL_HI:  phi_q <= $signed(v_q[VW-1:LOW]) * slope_q;
			CMD_MUL_LO:  plo_q <= $signed({1'b0, v_q[LOW-1:0]}) * slope_q;
			CMD_COMBINE: prod_q <= (PW'(phi_q) <<< LOW) + PW'(plo_q);
			CMD_ROUND: begin
				if (act_q && v_q < 0) res_q <= (prod_q + (PW'(1) <<< 25)) >>> 26;
				else res_q <= (pos_base + PW'(4096)) >>> 13;
			end
			default: ;
		endcase
	end

	// output word
	localparam logic signed [PW-1:0] SAT_HI = PW'((64'(1) << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd == CMD_EMIT) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_EMIT) begin
			if (res_q > SAT_HI) begin
				out_pixel <= 16'(SAT_HI);
				out_sat   <= 1'b1;
			end else if (res_q < SAT_LO) begin
				out_pixel <= 16'(SAT_LO);
				out_sat   <= 1'b1;
			end else begin
				out_pixel <= 16'(res_q);
				out_sat   <= 1'b0;
			end
			out_row  <= orow_q;
			out_col  <= 8'(ocol_q);
			out_last <= (ROWS_W'(orow_q) == rows_eff - 1'b1) &&
				(CLW'(ocol_q) == cols_eff - 1'b1);
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_EMIT |-> status.out_free) else $error("emit into a full output word");
	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1)) else $error("MAC stage 2 without stage 1");
	a_complete_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		complete_q |-> (irow_q == '0 && icol_q == '0 && iring_q == '0))
		else $error("input counters not parked after frame end");

endmodule

/* rtl/conv2d_replicate_pad_prelu_core.sv */
// Top level of the 2D replicate-pad convolution core with bias and PReLU.
// Depends on c2dpp_pkg, c2dpp_ctrl and c2dpp_dp.
//
// channel   direction  handshake          payload
// s_*       in         tvalid/tready      tuser: operation; tdata: coeff_index, sample_value
// m_*       out        tvalid/tready      tdata: pixel,row,col; tlast: frame_last; tuser: sat
// cfg_*     in         cfg_we             cfg_index, cfg_data
//
// An item that emits nothing goes back to idle after the window check; one that emits is paced
// by the single MAC walking the window through the line ring read port.
// Reset restores the register defaults and clears all frame counters; no clearing pass.
// A finished word waits in the output register while the next item is accepted;
// the next emit stalls only until that word is taken.
module conv2d_replicate_pad_prelu_core import c2dpp_pkg::*; #(
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [4:0] coeff_index, [20:5] sample_value, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] filtered_pixel, [25:16] out_row, [33:26] out_col
	output logic        m_tlast,
	output logic        m_tuser,   // [0] saturated
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic [15:0]      pix;
	logic [ROW_W-1:0] row;
	logic [7:0]       col;

	c2dpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	c2dpp_dp #(
		.MAX_COLS   (MAX_COLS),
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_op     (s_tuser),
		.in_cidx   (s_tdata[4:0]),
		.in_sample (s_tdata[20:5]),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pixel (pix),
		.out_row   (row),
		.out_col   (col),
		.out_last  (m_tlast),
		.out_sat   (m_tuser)
	);

	assign m_tdata = {6'd0, col, row, pix};

endmodule
